// ===== hw/rtl/sd_card_init_sequencer_top_defines.svh =====
// ----------------------------------------------------------------------------
// SD card init sequencer - assertion macros
// Shared assertion forms for the checker of the sequencer top level.
// ----------------------------------------------------------------------------
`ifndef SD_CARD_INIT_SEQUENCER_TOP_DEFINES_SVH
`define SD_CARD_INIT_SEQUENCER_TOP_DEFINES_SVH

// clocked assertion, switched off while reset is active
`define SDCI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define SDCI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/sdci_pkg.sv =====
// ----------------------------------------------------------------------------
// SD card init sequencer package
// Item types, register indexes, status codes and command constants.
// ----------------------------------------------------------------------------
package sdci_pkg;

  typedef struct packed {
    logic        mode;
    logic [39:0] response;
  } sdci_in_t;

  typedef struct packed {
    logic        send_valid;
    logic [15:0] frame_high;
    logic [31:0] frame_low;
    logic        frame_kind;
    logic [15:0] clock_divider;
    logic        done_res;
    logic [2:0]  status;
    logic        high_capacity;
  } sdci_out_t;

  // configuration register indexes
  localparam logic [2:0] REG_SLOW_DIV   = 3'd0;
  localparam logic [2:0] REG_FAST_DIV   = 3'd1;
  localparam logic [2:0] REG_ACMD41_LIM = 3'd2;
  localparam logic [2:0] REG_CMD1_LIM   = 3'd3;
  localparam logic [2:0] REG_BLOCK_LEN  = 3'd4;

  // reset values of the configuration registers
  localparam logic [15:0] SLOW_DIV_RST   = 16'd100;
  localparam logic [15:0] FAST_DIV_RST   = 16'd3;
  localparam logic [9:0]  ACMD41_LIM_RST = 10'd100;
  localparam logic [9:0]  CMD1_LIM_RST   = 10'd1000;
  localparam logic [12:0] BLOCK_LEN_RST  = 13'd512;

  // status codes
  localparam logic [2:0] STAT_BUSY    = 3'd0;
  localparam logic [2:0] STAT_OK      = 3'd1;
  localparam logic [2:0] STAT_NORESP  = 3'd2;
  localparam logic [2:0] STAT_VOLT    = 3'd3;
  localparam logic [2:0] STAT_TIMEOUT = 3'd4;

  // command indexes
  localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
  localparam logic [5:0] CMD_SEND_OP   = 6'd1;
  localparam logic [5:0] CMD_IF_COND   = 6'd8;
  localparam logic [5:0] CMD_BLOCKLEN  = 6'd16;
  localparam logic [5:0] CMD_SEND_OPAC = 6'd41;
  localparam logic [5:0] CMD_APP       = 6'd55;
  localparam logic [5:0] CMD_READ_OCR  = 6'd58;

  localparam logic [7:0]  CRC_CMD0  = 8'h95;
  localparam logic [7:0]  CRC_CMD8  = 8'h87;
  localparam logic [7:0]  CRC_NONE  = 8'hFF;
  localparam logic [31:0] ARG_CMD8  = 32'h0000_01AA;
  localparam logic [31:0] ARG_HCS   = 32'h4000_0000;
  localparam logic [15:0] DUMMY_HI  = 16'h4000;
  localparam logic [31:0] DUMMY_LO  = 32'h0000_0074;
  localparam logic [7:0]  R1_IDLE   = 8'h01;
  localparam logic [7:0]  R1_ILLCMD = 8'h05;
  localparam logic [7:0]  ECHO_PAT  = 8'hAA;
  localparam logic [7:0]  VOLT_OK   = 8'h01;

endpackage

// ===== hw/rtl/sd_card_init_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// SD card init sequencer - top level
// Steps an SD card through SPI-mode identification: a start item gives the
// dummy-clock frame, and a response item gives the next command frame if one
// is due (CMD0, CMD8, CMD55/ACMD41 or CMD1 with retry limits, CMD58, CMD16)
// together with the clock divider to use and the current status. One item
// is taken per clock unless stalled; its result is registered in the cycle
// after the item is accepted. The only stall comes from the output register:
// input ready drops while a result is held and not being taken. Configuration
// writes are always taken and belong in the idle gaps between sequences.
// ----------------------------------------------------------------------------
module sd_card_init_sequencer_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sdci_pkg::sdci_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sdci_pkg::sdci_out_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);
  import sdci_pkg::*;

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_DUMMY   = 4'd1;
  localparam logic [3:0] PH_CMD0    = 4'd2;
  localparam logic [3:0] PH_CMD8    = 4'd3;
  localparam logic [3:0] PH_CMD1    = 4'd4;
  localparam logic [3:0] PH_CMD55   = 4'd5;
  localparam logic [3:0] PH_ACMD41  = 4'd6;
  localparam logic [3:0] PH_CMD58   = 4'd7;
  localparam logic [3:0] PH_CMD16   = 4'd8;
  localparam logic [3:0] PH_OK      = 4'd9;
  localparam logic [3:0] PH_NORESP  = 4'd10;
  localparam logic [3:0] PH_VOLT    = 4'd11;
  localparam logic [3:0] PH_TIMEOUT = 4'd12;

  logic [15:0] slow_div_q, fast_div_q;
  logic [9:0]  acmd41_lim_q, cmd1_lim_q;
  logic [12:0] block_len_q;

  logic [3:0]  phase_q, phase_d;
  logic [9:0]  attempt_q, attempt_d;
  logic        cap_q, cap_d;

  logic        out_valid_q;
  sdci_out_t   out_data_q, res_d;
  logic        in_accept;

  logic        send, dummy;
  logic [5:0]  cmd_idx;
  logic [31:0] cmd_arg;
  logic [7:0]  crc;
  logic [7:0]  r1, low8;
  logic        old_card;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign r1   = in_data_i.response[39:32];
  assign low8 = in_data_i.response[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_div_q   <= SLOW_DIV_RST;
      fast_div_q   <= FAST_DIV_RST;
      acmd41_lim_q <= ACMD41_LIM_RST;
      cmd1_lim_q   <= CMD1_LIM_RST;
      block_len_q  <= BLOCK_LEN_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SLOW_DIV:   slow_div_q   <= cfg_data_i;
        REG_FAST_DIV:   fast_div_q   <= cfg_data_i;
        REG_ACMD41_LIM: acmd41_lim_q <= cfg_data_i[9:0];
        REG_CMD1_LIM:   cmd1_lim_q   <= cfg_data_i[9:0];
        REG_BLOCK_LEN:  block_len_q  <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // next phase and the frame to send
  always_comb begin
    phase_d   = phase_q;
    attempt_d = attempt_q;
    cap_d     = cap_q;
    send      = 1'b0;
    dummy     = 1'b0;
    cmd_idx   = CMD_GO_IDLE;
    cmd_arg   = '0;
    old_card  = 1'b0;
    if (!in_data_i.mode) begin
      phase_d   = PH_DUMMY;
      attempt_d = '0;
      cap_d     = 1'b0;
      send      = 1'b1;
      dummy     = 1'b1;
    end else begin
      unique case (phase_q)
        PH_DUMMY: begin
          send    = 1'b1;
          cmd_idx = CMD_GO_IDLE;
          phase_d = PH_CMD0;
        end
        PH_CMD0: begin
          if (low8 == R1_IDLE) begin
            send    = 1'b1;
            cmd_idx = CMD_IF_COND;
            cmd_arg = ARG_CMD8;
            phase_d = PH_CMD8;
          end else begin
            phase_d = PH_NORESP;
          end
        end
        PH_CMD8: begin
          // idle card that echoes the pattern but rejects the voltage
          if (r1 == R1_IDLE && low8 == ECHO_PAT
              && in_data_i.response[15:8] != VOLT_OK) begin
            phase_d = PH_VOLT;
          end else begin
            old_card  = (r1 == R1_ILLCMD);
            attempt_d = 10'd1;
            send      = 1'b1;
            cmd_idx   = old_card ? CMD_SEND_OP : CMD_APP;
            phase_d   = old_card ? PH_CMD1 : PH_CMD55;
          end
        end
        PH_CMD1: begin
          if (low8 == 8'h00) begin
            send    = 1'b1;
            cmd_idx = CMD_BLOCKLEN;
            cmd_arg = {19'd0, block_len_q};
            phase_d = PH_CMD16;
          end else if (attempt_q >= cmd1_lim_q) begin
            phase_d = PH_TIMEOUT;
          end else begin
            attempt_d = attempt_q + 10'd1;
            send      = 1'b1;
            cmd_idx   = CMD_SEND_OP;
          end
        end
        PH_CMD55: begin
          send    = 1'b1;
          cmd_idx = CMD_SEND_OPAC;
          cmd_arg = ARG_HCS;
          phase_d = PH_ACMD41;
        end
        PH_ACMD41: begin
          if (low8 == 8'h00) begin
            send    = 1'b1;
            cmd_idx = CMD_READ_OCR;
            phase_d = PH_CMD58;
          end else if (attempt_q >= acmd41_lim_q) begin
            phase_d = PH_TIMEOUT;
          end else begin
            attempt_d = attempt_q + 10'd1;
            send      = 1'b1;
            cmd_idx   = CMD_APP;
            phase_d   = PH_CMD55;
          end
        end
        PH_CMD58: begin
          cap_d   = in_data_i.response[30];
          send    = 1'b1;
          cmd_idx = CMD_BLOCKLEN;
          cmd_arg = {19'd0, block_len_q};
          phase_d = PH_CMD16;
        end
        PH_CMD16: phase_d = PH_OK;
        default: ;
      endcase
    end
  end

  // result item
  always_comb begin
    priority if (cmd_idx == CMD_GO_IDLE) crc = CRC_CMD0;
    else if (cmd_idx == CMD_IF_COND)     crc = CRC_CMD8;
    else                                 crc = CRC_NONE;

    res_d = '0;
    if (dummy) begin
      res_d.send_valid = 1'b1;
      res_d.frame_high = DUMMY_HI;
      res_d.frame_low  = DUMMY_LO;
      res_d.frame_kind = 1'b1;
    end else if (send) begin
      res_d.send_valid = 1'b1;
      res_d.frame_high = {2'b01, cmd_idx, cmd_arg[31:24]};
      res_d.frame_low  = {cmd_arg[23:0], crc};
    end
    res_d.clock_divider = (phase_d == PH_OK) ? fast_div_q : slow_div_q;
    res_d.done_res      = (phase_d >= PH_OK);
    unique case (phase_d)
      PH_OK:      res_d.status = STAT_OK;
      PH_NORESP:  res_d.status = STAT_NORESP;
      PH_VOLT:    res_d.status = STAT_VOLT;
      PH_TIMEOUT: res_d.status = STAT_TIMEOUT;
      default:    res_d.status = STAT_BUSY;
    endcase
    res_d.high_capacity = cap_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      attempt_q   <= '0;
      cap_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        phase_q   <= phase_d;
        attempt_q <= attempt_d;
        cap_q     <= cap_d;
      end
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= res_d;
    end
  end

endmodule

// ===== hw/rtl/sdci_checker.sv =====
// ----------------------------------------------------------------------------
// SD card init sequencer - port checker
// Watches the top level ports and flags inconsistent result items.
// ----------------------------------------------------------------------------
`include "sd_card_init_sequencer_top_defines.svh"

module sdci_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_o,
  input  sdci_pkg::sdci_in_t  in_data_i,
  input  logic                out_valid_o,
  input  logic                out_ready_i,
  input  sdci_pkg::sdci_out_t out_data_o
);
  import sdci_pkg::*;

  // a stalled result item holds
  `SDCI_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "result item changed while stalled")

  // every accepted item yields a result in the next cycle
  `SDCI_ASSERT(a_in_to_out, clk_i, rst_ni, in_valid_i && in_ready_o |=> out_valid_o, "accepted item gave no result")

  // a start item always gives the dummy clocks frame
  `SDCI_ASSERT(a_start_dummy, clk_i, rst_ni, in_valid_i && in_ready_o && !in_data_i.mode |=> out_data_o.send_valid && out_data_o.frame_kind && out_data_o.status == STAT_BUSY, "start item gave no dummy frame")

  // no frame means empty frame fields
  `SDCI_ASSERT_ALWAYS(a_empty_frame, clk_i, out_valid_o && !out_data_o.send_valid |-> out_data_o.frame_high == 16'd0 && out_data_o.frame_low == 32'd0 && !out_data_o.frame_kind, "frame fields set without a frame")

  // an ended sequence sends nothing and reports a cause
  `SDCI_ASSERT(a_done_status, clk_i, rst_ni, out_valid_o && out_data_o.done_res |-> !out_data_o.send_valid && out_data_o.status != STAT_BUSY, "ended sequence inconsistent")

endmodule

bind sd_card_init_sequencer_top sdci_checker u_sdci_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== tb/sd_card_init_sequencer_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SD card init sequencer - testbench
// Sends start and card-response items into the sequencer, checks every result.
// A behavioural init-flow model predicts each result the directed table leaves
// open; the check compares field by field. The run covers that table, then
// random card conversations over several register settings and handshake loads.
// ----------------------------------------------------------------------------
module sd_card_init_sequencer_top_tb;
  import sdci_pkg::*;

  localparam logic       MODE_START  = 1'b0;
  localparam logic       MODE_RESP   = 1'b1;
  localparam logic       KIND_CMD    = 1'b0;
  localparam logic       KIND_DUMMY  = 1'b1;
  localparam logic [2:0] CFG_IDX_MAX = 3'd7;
  localparam int         STALL_LIMIT = 2000;
  localparam int         PHASE_ITEMS = 290;
  localparam int         N_PHASES    = 6;

  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_DUMMY, SEQ_CMD0, SEQ_CMD8, SEQ_CMD1, SEQ_CMD55, SEQ_ACMD41,
    SEQ_CMD58, SEQ_CMD16, SEQ_OK, SEQ_NORESP, SEQ_VOLT, SEQ_TIMEOUT
  } seq_phase_e;

  typedef struct packed {
    sdci_in_t  stim;
    logic      typed;
    sdci_out_t res;
  } dir_row_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  sdci_in_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  sdci_out_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  // register copies and sequence state of the card model
  logic [15:0] slow_div   = SLOW_DIV_RST;
  logic [15:0] fast_div   = FAST_DIV_RST;
  logic [9:0]  acmd41_lim = ACMD41_LIM_RST;
  logic [9:0]  cmd1_lim   = CMD1_LIM_RST;
  logic [12:0] blk_len    = BLOCK_LEN_RST;
  seq_phase_e  seq_ph     = SEQ_IDLE;
  logic [9:0]  tries      = '0;
  logic        old_card   = 1'b0;
  logic        ccs        = 1'b0;

  sdci_out_t pending_frames[$];
  int errs      = 0;
  int n_items   = 0;
  int n_results = 0;
  int n_ok      = 0;
  int n_abort   = 0;
  int stall     = 0;
  int idle_mode = 0;

  sd_card_init_sequencer_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic sdci_out_t mk_res(logic sv, logic [15:0] hi, logic [31:0] lo,
                                       logic kind, logic [15:0] div, logic done,
                                       logic [2:0] st, logic hc);
    sdci_out_t r;
    r.send_valid    = sv;
    r.frame_high    = hi;
    r.frame_low     = lo;
    r.frame_kind    = kind;
    r.clock_divider = div;
    r.done_res      = done;
    r.status        = st;
    r.high_capacity = hc;
    return r;
  endfunction

  function automatic sdci_out_t cmd_frame(logic [5:0] idx, logic [31:0] arg);
    sdci_out_t r;
    logic [7:0] crc;
    r = '0;
    crc = (idx == CMD_IF_COND) ? CRC_CMD8 : (idx == CMD_GO_IDLE) ? CRC_CMD0 : CRC_NONE;
    r.send_valid = 1'b1;
    r.frame_high = {2'b01, idx, arg[31:24]};
    r.frame_low  = {arg[23:0], crc};
    r.frame_kind = KIND_CMD;
    return r;
  endfunction

  // advances the card model by one item and returns the frame and status due
  function automatic sdci_out_t next_card_frame(sdci_in_t it);
    sdci_out_t r;
    logic [7:0] r1;
    logic [7:0] low8;
    r    = '0;
    r1   = it.response[39:32];
    low8 = it.response[7:0];
    if (it.mode == MODE_START) begin
      seq_ph   = SEQ_DUMMY;
      tries    = '0;
      old_card = 1'b0;
      ccs      = 1'b0;
      r = mk_res(1'b1, DUMMY_HI, DUMMY_LO, KIND_DUMMY, '0, 1'b0, STAT_BUSY, 1'b0);
    end else begin
      case (seq_ph)
        SEQ_DUMMY: begin
          r = cmd_frame(CMD_GO_IDLE, '0);
          seq_ph = SEQ_CMD0;
        end
        SEQ_CMD0: begin
          if (low8 == R1_IDLE) begin
            r = cmd_frame(CMD_IF_COND, ARG_CMD8);
            seq_ph = SEQ_CMD8;
          end else begin
            seq_ph = SEQ_NORESP;
          end
        end
        SEQ_CMD8: begin
          old_card = (r1 == R1_ILLCMD);
          // echo matches but the card rejects the voltage window
          if (r1 == R1_IDLE && low8 == ECHO_PAT && it.response[15:8] != VOLT_OK) begin
            seq_ph = SEQ_VOLT;
          end else begin
            tries = 10'd1;
            if (old_card) begin
              r = cmd_frame(CMD_SEND_OP, '0);
              seq_ph = SEQ_CMD1;
            end else begin
              r = cmd_frame(CMD_APP, '0);
              seq_ph = SEQ_CMD55;
            end
          end
        end
        SEQ_CMD1: begin
          if (low8 == 8'h00) begin
            r = cmd_frame(CMD_BLOCKLEN, {19'b0, blk_len});
            seq_ph = SEQ_CMD16;
          end else if (tries >= cmd1_lim) begin
            seq_ph = SEQ_TIMEOUT;
          end else begin
            tries = tries + 10'd1;
            r = cmd_frame(CMD_SEND_OP, '0);
          end
        end
        SEQ_CMD55: begin
          r = cmd_frame(CMD_SEND_OPAC, ARG_HCS);
          seq_ph = SEQ_ACMD41;
        end
        SEQ_ACMD41: begin
          if (low8 == 8'h00) begin
            r = cmd_frame(CMD_READ_OCR, '0);
            seq_ph = SEQ_CMD58;
          end else if (tries >= acmd41_lim) begin
            seq_ph = SEQ_TIMEOUT;
          end else begin
            tries = tries + 10'd1;
            r = cmd_frame(CMD_APP, '0);
            seq_ph = SEQ_CMD55;
          end
        end
        SEQ_CMD58: begin
          ccs = it.response[30];
          r = cmd_frame(CMD_BLOCKLEN, {19'b0, blk_len});
          seq_ph = SEQ_CMD16;
        end
        SEQ_CMD16: seq_ph = SEQ_OK;
        default: ;  // idle or ended: item has no effect
      endcase
    end
    r.clock_divider = (seq_ph == SEQ_OK) ? fast_div : slow_div;
    r.done_res      = (seq_ph >= SEQ_OK);
    case (seq_ph)
      SEQ_OK:      r.status = STAT_OK;
      SEQ_NORESP:  r.status = STAT_NORESP;
      SEQ_VOLT:    r.status = STAT_VOLT;
      SEQ_TIMEOUT: r.status = STAT_TIMEOUT;
      default:     r.status = STAT_BUSY;
    endcase
    r.high_capacity = ccs;
    return r;
  endfunction

  // mostly plausible card answers for the current step, some noise and restarts
  function automatic sdci_in_t pick_item();
    sdci_in_t it;
    int dice;
    dice = $urandom_range(0, 99);
    it.mode     = MODE_RESP;
    it.response = {8'($urandom), $urandom};
    if (seq_ph == SEQ_IDLE || seq_ph >= SEQ_OK) begin
      if (dice < 90) it.mode = MODE_START;
    end else if (dice < 4) begin
      it.mode = MODE_START;
    end else begin
      case (seq_ph)
        SEQ_CMD0: if (dice < 90) it.response[7:0] = R1_IDLE;
        SEQ_CMD8: begin
          if (dice < 50) begin
            it.response[39:32] = R1_IDLE;
            it.response[15:8]  = VOLT_OK;
            it.response[7:0]   = ECHO_PAT;
          end else if (dice < 75) begin
            it.response[39:32] = R1_ILLCMD;
          end else if (dice < 85) begin
            it.response[39:32] = R1_IDLE;
            it.response[7:0]   = ECHO_PAT;
          end else if (dice < 92) begin
            it.response[39:32] = R1_IDLE;
          end
        end
        SEQ_CMD1, SEQ_ACMD41: if (dice < 35) it.response[7:0] = 8'h00;
        default: ;
      endcase
    end
    return it;
  endfunction

  function automatic dir_row_t dir_row(logic md, logic [39:0] rsp, logic typed,
                                       sdci_out_t res);
    dir_row_t row;
    row.stim.mode     = md;
    row.stim.response = rsp;
    row.typed         = typed;
    row.res           = res;
    return row;
  endfunction

  task automatic send_item(input sdci_in_t it, input logic typed, input sdci_out_t typed_res);
    int gap;
    int pct;
    seq_phase_e prev;
    sdci_out_t pred;
    pct = (idle_mode == 0) ? 37 : (idle_mode == 1) ? 78 : 0;
    gap = 0;
    while ($urandom_range(0, 99) < pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    prev = seq_ph;
    pred = next_card_frame(it);
    pending_frames.push_back(typed ? typed_res : pred);
    n_items++;
    if (prev < SEQ_OK && seq_ph >= SEQ_OK) begin
      if (seq_ph == SEQ_OK) n_ok++;
      else n_abort++;
    end
  endtask

  task automatic run_random(input int quota);
    int live;
    sdci_in_t it;
    live = 0;
    while (live < quota) begin
      it = pick_item();
      // responses while idle or ended are ignored and do not count
      if (it.mode == MODE_START || (seq_ph != SEQ_IDLE && seq_ph < SEQ_OK)) live++;
      send_item(it, 1'b0, '0);
    end
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SLOW_DIV:   slow_div   = val;
      REG_FAST_DIV:   fast_div   = val;
      REG_ACMD41_LIM: acmd41_lim = val[9:0];
      REG_CMD1_LIM:   cmd1_lim   = val[9:0];
      REG_BLOCK_LEN:  blk_len    = val[12:0];
      default: ;  // unmapped index
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cmp_field(input string nm, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, nm, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >=
                  ((idle_mode == 0) ? 78 : (idle_mode == 1) ? 37 : 0));
  end

  always @(posedge clk) begin : res_check
    sdci_out_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending_frames.size() == 0) begin
        $display("%0t: result with nothing pending, got %h", $time, out_data);
        errs++;
      end else begin
        want = pending_frames.pop_front();
        cmp_field("send_valid", 32'(want.send_valid), 32'(out_data.send_valid));
        cmp_field("frame_high", 32'(want.frame_high), 32'(out_data.frame_high));
        cmp_field("frame_low", want.frame_low, out_data.frame_low);
        cmp_field("frame_kind", 32'(want.frame_kind), 32'(out_data.frame_kind));
        cmp_field("clock_divider", 32'(want.clock_divider), 32'(out_data.clock_divider));
        cmp_field("done_res", 32'(want.done_res), 32'(out_data.done_res));
        cmp_field("status", 32'(want.status), 32'(out_data.status));
        cmp_field("high_capacity", 32'(want.high_capacity), 32'(out_data.high_capacity));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall <= 0;
    end else begin
      stall <= stall + 1;
      if (stall >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("sd_card_init_sequencer_top test failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    sdci_out_t res_none, res_start, res_cmd0, res_cmd8, res_noresp, res_volt;
    sdci_out_t res_ok_hc, res_ok;
    dir_row_t rows[$];
    res_none   = mk_res(1'b0, '0, '0, KIND_CMD, SLOW_DIV_RST, 1'b0, STAT_BUSY, 1'b0);
    res_start  = mk_res(1'b1, DUMMY_HI, DUMMY_LO, KIND_DUMMY, SLOW_DIV_RST, 1'b0,
                        STAT_BUSY, 1'b0);
    res_cmd0   = mk_res(1'b1, {2'b01, CMD_GO_IDLE, 8'h00}, {24'h0, CRC_CMD0}, KIND_CMD,
                        SLOW_DIV_RST, 1'b0, STAT_BUSY, 1'b0);
    res_cmd8   = mk_res(1'b1, {2'b01, CMD_IF_COND, ARG_CMD8[31:24]},
                        {ARG_CMD8[23:0], CRC_CMD8}, KIND_CMD, SLOW_DIV_RST, 1'b0,
                        STAT_BUSY, 1'b0);
    res_noresp = mk_res(1'b0, '0, '0, KIND_CMD, SLOW_DIV_RST, 1'b1, STAT_NORESP, 1'b0);
    res_volt   = mk_res(1'b0, '0, '0, KIND_CMD, SLOW_DIV_RST, 1'b1, STAT_VOLT, 1'b0);
    res_ok_hc  = mk_res(1'b0, '0, '0, KIND_CMD, FAST_DIV_RST, 1'b1, STAT_OK, 1'b1);
    res_ok     = mk_res(1'b0, '0, '0, KIND_CMD, FAST_DIV_RST, 1'b1, STAT_OK, 1'b0);

    // response before any start, then a card that never answers CMD0
    rows.push_back(dir_row(MODE_RESP,  40'hFF_FFFF_FFFF, 1'b1, res_none));
    rows.push_back(dir_row(MODE_START, 40'hFF_FFFF_FFFF, 1'b1, res_start));
    rows.push_back(dir_row(MODE_RESP,  40'hFF_FFFF_FFFF, 1'b1, res_cmd0));
    rows.push_back(dir_row(MODE_RESP,  40'h00_0000_0000, 1'b1, res_noresp));
    rows.push_back(dir_row(MODE_RESP,  40'h01_0000_0001, 1'b1, res_noresp));
    // voltage window rejected
    rows.push_back(dir_row(MODE_START, 40'h00_0000_0000, 1'b1, res_start));
    rows.push_back(dir_row(MODE_RESP,  40'h00_0000_0000, 1'b1, res_cmd0));
    rows.push_back(dir_row(MODE_RESP,  40'h00_0000_0001, 1'b1, res_cmd8));
    rows.push_back(dir_row(MODE_RESP,  40'h01_0000_02AA, 1'b1, res_volt));
    // echo mismatch taken as new card, one busy round, then restart mid-way
    rows.push_back(dir_row(MODE_START, 40'h00_0000_0000, 1'b1, res_start));
    rows.push_back(dir_row(MODE_RESP,  40'h00_0000_0000, 1'b0, '0));
    rows.push_back(dir_row(MODE_RESP,  40'h00_0000_0001, 1'b0, '0));
    rows.push_back(dir_row(MODE_RESP,  40'h01_0000_0155, 1'b0, '0));
    rows.push_back(dir_row(MODE_RESP,  40'h00_0000_0000, 1'b0, '0));
    rows.push_back(dir_row(MODE_RESP,  40'h00_0000_0001, 1'b0, '0));
    rows.push_back(dir_row(MODE_START, 40'hFF_FFFF_FFFF, 1'b1, res_start));
    // odd CMD8 R1 gives new card, high capacity through to the end
    rows.push_back(dir_row(MODE_RESP,  40'h00_0000_0000, 1'b1, res_cmd0));
    rows.push_back(dir_row(MODE_RESP,  40'h00_0000_0001, 1'b1, res_cmd8));
    rows.push_back(dir_row(MODE_RESP,  40'h3C_0000_0000, 1'b0, '0));
    rows.push_back(dir_row(MODE_RESP,  40'h00_0000_0000, 1'b0, '0));
    rows.push_back(dir_row(MODE_RESP,  40'h00_0000_0000, 1'b0, '0));
    rows.push_back(dir_row(MODE_RESP,  40'h00_4000_0000, 1'b0, '0));
    rows.push_back(dir_row(MODE_RESP,  40'h00_0000_0000, 1'b1, res_ok_hc));
    // old card through CMD1
    rows.push_back(dir_row(MODE_START, 40'h00_0000_0000, 1'b1, res_start));
    rows.push_back(dir_row(MODE_RESP,  40'h00_0000_0000, 1'b0, '0));
    rows.push_back(dir_row(MODE_RESP,  40'h00_0000_0001, 1'b0, '0));
    rows.push_back(dir_row(MODE_RESP,  40'h05_FFFF_FFFF, 1'b0, '0));
    rows.push_back(dir_row(MODE_RESP,  40'h00_0000_0001, 1'b0, '0));
    rows.push_back(dir_row(MODE_RESP,  40'hFF_FFFF_FF00, 1'b0, '0));
    rows.push_back(dir_row(MODE_RESP,  40'hFF_FFFF_FFFF, 1'b1, res_ok));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_item(rows[i].stim, rows[i].typed, rows[i].res);
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      idle_mode = p / 2;
      case (p)
        0: begin
          cfg_write(REG_SLOW_DIV, 16'd1);
          cfg_write(REG_FAST_DIV, 16'hFFFF);
          cfg_write(REG_ACMD41_LIM, 16'd1);
          cfg_write(REG_CMD1_LIM, 16'd1);
          cfg_write(REG_BLOCK_LEN, 16'd1);
        end
        1: begin
          cfg_write(REG_SLOW_DIV, 16'hFFFF);
          cfg_write(REG_FAST_DIV, 16'd1);
          cfg_write(REG_ACMD41_LIM, 16'd1023);
          cfg_write(REG_CMD1_LIM, 16'd1023);
          cfg_write(REG_BLOCK_LEN, 16'd4096);
        end
        2: begin
          // zero limits act as one; oversized values are cut to register width
          cfg_write(REG_ACMD41_LIM, 16'd0);
          cfg_write(REG_CMD1_LIM, 16'hFC00);
          cfg_write(REG_BLOCK_LEN, 16'hFFFF);
          cfg_write(REG_FAST_DIV, 16'hA5A5);
          cfg_write(3'($urandom_range(REG_BLOCK_LEN + 1, CFG_IDX_MAX)), 16'($urandom));
        end
        default: begin
          cfg_write(REG_SLOW_DIV, 16'($urandom_range(1, 65535)));
          cfg_write(REG_FAST_DIV, 16'($urandom_range(1, 65535)));
          cfg_write(REG_ACMD41_LIM, 16'($urandom_range(1, 8)));
          cfg_write(REG_CMD1_LIM, 16'($urandom_range(1, 8)));
          cfg_write(REG_BLOCK_LEN, 16'($urandom_range(1, 4096)));
        end
      endcase
      cfg_valid <= 1'b0;
      run_random(PHASE_ITEMS);
      drain();
    end

    $display("run covered %0d items and %0d checked results over %0d register settings",
             n_items, n_results, N_PHASES + 1);
    $display("sequences ended: %0d ok, %0d with a fault code", n_ok, n_abort);
    if (errs == 0) begin
      $display("sd_card_init_sequencer_top test passed");
    end else begin
      $display("sd_card_init_sequencer_top test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/sdci_pkg.sv
hw/rtl/sd_card_init_sequencer_top.sv
hw/rtl/sdci_checker.sv
tb/sd_card_init_sequencer_top_tb.sv
